@@ rtl/jae_pkg.sv @@
package jae_pkg;

  localparam int unsigned NumButtons = 6;
  localparam int unsigned ButtonW    = 3;
  localparam int unsigned SampleW    = 8;
  localparam int unsigned CountW     = 8;

  typedef logic [ButtonW-1:0] button_t;
  typedef logic [SampleW-1:0] sample_t;
  typedef logic [CountW-1:0]  count_t;

  // button codes, priority follows the code order
  localparam button_t BtnUp    = 3'd0;
  localparam button_t BtnDown  = 3'd1;
  localparam button_t BtnLeft  = 3'd2;
  localparam button_t BtnRight = 3'd3;
  localparam button_t BtnFire1 = 3'd4;
  localparam button_t BtnFire2 = 3'd5;

  typedef enum logic {
    KIND_PRESSED  = 1'b0,
    KIND_RELEASED = 1'b1
  } kind_t;

  // register word indexes on the configuration port
  localparam logic RegInitialDelay = 1'b0;
  localparam logic RegRepeatPeriod = 1'b1;

  // per-sample tracking state
  typedef struct packed {
    count_t  countdown;
    logic    repeating;
    sample_t previous_sample;
  } track_t;

  // one event leaving the core
  typedef struct packed {
    logic    valid;
    button_t button;
    kind_t   kind;
    sample_t sample;
  } event_t;

  // lowest set bit among the six button bits
  function automatic button_t pick_button(input sample_t s);
    button_t b;
    b = BtnUp;
    for (int i = NumButtons - 1; i >= 0; i--) begin
      if (s[i]) begin
        b = button_t'(i);
      end
    end
    return b;
  endfunction

endpackage

@@ rtl/jae_core.sv @@
module jae_core (
  input  jae_pkg::sample_t sample,
  input  jae_pkg::track_t  cur,
  input  jae_pkg::count_t  initial_delay,
  input  jae_pkg::count_t  repeat_period,
  output jae_pkg::track_t  nxt,
  output jae_pkg::event_t  evt
);
  import jae_pkg::*;

  logic    zero_sample;
  logic    any_held;
  logic    prev_any_held;
  button_t cur_btn;
  button_t prev_btn;
  count_t  dec_count;

  assign zero_sample   = (sample == '0);
  assign any_held      = |sample[NumButtons-1:0];
  assign prev_any_held = |cur.previous_sample[NumButtons-1:0];
  assign cur_btn       = pick_button(sample);
  assign prev_btn      = pick_button(cur.previous_sample);
  assign dec_count     = (cur.countdown != '0) ? cur.countdown - count_t'(1) : '0;

  // event decision and state update for one sample
  always_comb begin
    nxt                 = cur;
    nxt.previous_sample = sample;
    evt.valid           = 1'b0;
    evt.button          = cur_btn;
    evt.kind            = KIND_PRESSED;
    evt.sample          = sample;
    if (zero_sample) begin
      nxt.countdown = '0;
      nxt.repeating = 1'b0;
      evt.valid     = prev_any_held;
      evt.button    = prev_btn;
      evt.kind      = KIND_RELEASED;
    end else if (any_held && cur_btn < BtnFire1) begin
      // direction held: count down, fire and reload at zero
      nxt.countdown = dec_count;
      if (dec_count == '0) begin
        evt.valid     = 1'b1;
        nxt.repeating = 1'b1;
        nxt.countdown = cur.repeating ? repeat_period : initial_delay;
      end
    end else if (any_held) begin
      // fire button: rising edge only
      evt.valid = ~cur.previous_sample[cur_btn];
    end
  end

endmodule

@@ rtl/joystick_autorepeat_events_unit.sv @@
// Joystick autorepeat event unit: takes one polled joystick sample per request
// and returns at most one button event for it. The highest-priority held button
// (up, down, left, right, fire1, fire2) is chosen; a held direction repeats with
// initial_delay ticks before the first repeat and repeat_period ticks after that,
// a fire button gives one press on its rising edge, and an all-zero sample gives
// a release for the button held before. Samples that cause no event produce no
// result. A sample is accepted every cycle while the output register is empty or
// being drained; the event logic is one combinational pass between the tracking
// registers and the output register, which holds the result in the cycle after
// the sample is accepted. Registers sit at byte address 0 (initial_delay) and 4
// (repeat_period), written by the user only while the unit is idle (unchecked).
module joystick_autorepeat_events_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  // sample channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  jae_pkg::sample_t      in_joy_sample,
  // event channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output jae_pkg::button_t      out_button,
  output logic                  out_event_kind,
  output jae_pkg::sample_t      out_sample_echo,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import jae_pkg::*;

  track_t  track_r;
  track_t  track_nxt;
  event_t  evt;
  count_t  initial_delay_r;
  count_t  repeat_period_r;
  logic    out_valid_r;
  button_t out_button_r;
  kind_t   out_kind_r;
  sample_t out_sample_r;
  logic    in_take;
  logic    cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign in_ready  = ~out_valid_r | out_ready;
  assign in_take   = in_valid & in_ready;

  // register read back
  always_comb begin
    unique case (paddr[2])
      RegInitialDelay: prdata = {24'd0, initial_delay_r};
      RegRepeatPeriod: prdata = {24'd0, repeat_period_r};
      default:         prdata = '0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_delay_r <= count_t'(30);
      repeat_period_r <= count_t'(6);
    end else if (cfg_write) begin
      if (paddr[2] == RegInitialDelay) begin
        initial_delay_r <= pwdata[CountW-1:0];
      end else begin
        repeat_period_r <= pwdata[CountW-1:0];
      end
    end
  end

  jae_core u_core (
    .sample        (in_joy_sample),
    .cur           (track_r),
    .initial_delay (initial_delay_r),
    .repeat_period (repeat_period_r),
    .nxt           (track_nxt),
    .evt           (evt)
  );

  // tracking state advances on each accepted sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r <= '0;
    end else if (in_take) begin
      track_r <= track_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_take & evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && evt.valid) begin
      out_button_r <= evt.button;
      out_kind_r   <= evt.kind;
      out_sample_r <= evt.sample;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_button      = out_button_r;
  assign out_event_kind  = out_kind_r;
  assign out_sample_echo = out_sample_r;

  // releases carry an all-zero sample, presses never do
  a_release_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_kind_r == KIND_RELEASED) == (out_sample_r == '0)))
    else $error("release flag and echoed sample disagree");

  // only six buttons exist
  a_button_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_button_r <= BtnFire2))
    else $error("event button out of range");

  // an all-zero sample clears the repeat tracking
  a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_joy_sample == '0) |=> (track_r.countdown == '0 && !track_r.repeating))
    else $error("zero sample did not clear countdown");

  // a direction press reloads the countdown from the right register
  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && evt.valid && evt.kind == KIND_PRESSED && evt.button < BtnFire1) |=>
      (track_r.repeating &&
       track_r.countdown == ($past(track_r.repeating) ? $past(repeat_period_r)
                                                      : $past(initial_delay_r))))
    else $error("countdown reload mismatch");

  // an empty output register never holds off a sample
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

@@ tb/tb_joystick_autorepeat_events_unit.sv @@
module tb_joystick_autorepeat_events_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import jae_pkg::*;

  localparam int SettleCycles    = 4;
  localparam int LongStallCycles = 300;
  localparam int WatchdogLimit   = 2000;
  localparam int EndLimit        = 1000;
  localparam int PhaseSamples    = 85;

  // one expected button event
  typedef struct {
    button_t button;
    kind_t   kind;
    sample_t sample;
  } joy_event_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  sample_t     in_joy_sample;
  logic        out_valid;
  logic        out_ready;
  button_t     out_button;
  logic        out_event_kind;
  sample_t     out_sample_echo;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predicted state of the unit
  logic [7:0]  delay_model;
  logic [7:0]  period_model;
  count_t      countdown_model;
  logic        repeating_model;
  sample_t     last_sample_model;
  joy_event_t  pending_events[$];

  // run control and bookkeeping
  bit          sender_gaps;
  bit          receiver_gaps;
  bit          long_stall_req;
  int          error_count;
  int          samples_sent;
  int          events_checked;
  int          register_writes;

  joystick_autorepeat_events_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_joy_sample  (in_joy_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_button     (out_button),
    .out_event_kind (out_event_kind),
    .out_sample_echo(out_sample_echo),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // lowest held button bit, NumButtons when none of bits 0 to 5 is set
  function automatic button_t first_held(input sample_t s);
    button_t found;
    bit      hit;
    found = button_t'(NumButtons);
    hit   = 1'b0;
    for (int i = 0; i < NumButtons; i++) begin
      if (!hit && s[i]) begin
        found = button_t'(i);
        hit   = 1'b1;
      end
    end
    return found;
  endfunction

  // advance the predicted state by one sample and queue its event, if any
  task automatic predict_joy_event(input sample_t s);
    button_t b;
    b = first_held(s);
    if (s == '0) begin
      countdown_model = '0;
      repeating_model = 1'b0;
      b = first_held(last_sample_model);
      if (b < NumButtons) begin
        pending_events.push_back('{b, KIND_RELEASED, s});
      end
    end else if (b < BtnFire1) begin
      if (countdown_model != '0) begin
        countdown_model = countdown_model - 1'b1;
      end
      if (countdown_model == '0) begin
        pending_events.push_back('{b, KIND_PRESSED, s});
        if (!repeating_model) begin
          repeating_model = 1'b1;
          countdown_model = delay_model;
        end else begin
          countdown_model = period_model;
        end
      end
    end else if (b < NumButtons && !last_sample_model[b]) begin
      pending_events.push_back('{b, KIND_PRESSED, s});
    end
    last_sample_model = s;
  endtask

  // compare each event with the oldest prediction, then predict new requests
  always @(posedge clk) begin : event_check
    joy_event_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected event button %0d kind %0d sample %02h", $time,
                   out_button, out_event_kind, out_sample_echo);
          error_count++;
        end else begin
          want = pending_events.pop_front();
          if (out_button !== want.button) begin
            $display("%0t: button expected %0d actual %0d", $time, want.button, out_button);
            error_count++;
          end
          if (out_event_kind !== want.kind) begin
            $display("%0t: event_kind expected %0d actual %0d", $time, want.kind,
                     out_event_kind);
            error_count++;
          end
          if (out_sample_echo !== want.sample) begin
            $display("%0t: sample_echo expected %02h actual %02h", $time, want.sample,
                     out_sample_echo);
            error_count++;
          end
          events_checked++;
        end
      end
      if (in_valid && in_ready) begin
        predict_joy_event(in_joy_sample);
        samples_sent++;
      end
    end
  end

  // event receiver: random hold-off per event, plus one long stall on request
  initial begin : event_receiver
    int gap;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_req) begin
        out_ready <= 1'b0;
        repeat (LongStallCycles) @(negedge clk);
        long_stall_req = 1'b0;
      end
      gap = receiver_gaps ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ends the run when no request moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (psel && penable && pwrite && pready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: timeout, no request moved for %0d cycles", $time, WatchdogLimit);
    $display("Some tests failed");
    $finish;
  end

  // offer one sample and hold it until accepted; valid stays high on return
  task automatic send_sample(input sample_t s);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_joy_sample <= s;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // let every predicted event drain and the pipeline settle
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // setup and access phase, upper data bits carry noise, then the bus returns to idle
  task automatic write_register(input logic reg_idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {24'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == RegInitialDelay) begin
      delay_model = value;
    end else begin
      period_model = value;
    end
    register_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // all-zero and upper-bit-only samples, release with nothing held before
  task automatic test_release_cases();
    sample_t seq[5] = '{8'h00, 8'hC0, 8'h00, 8'h40, 8'h80};
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  // fire buttons press only on a rising edge, held fire stays silent
  task automatic test_fire_edges();
    sample_t seq[7] = '{8'h10, 8'h10, 8'h30, 8'h20, 8'h00, 8'hE0, 8'h00};
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b1;
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  // zero reloads repeat on every tick, each direction wins in priority order
  task automatic test_zero_reload();
    sample_t seq[7] = '{8'h01, 8'h01, 8'h3F, 8'h3E, 8'h3C, 8'hF8, 8'h00};
    wait_for_idle();
    write_register(RegInitialDelay, 8'd0);
    write_register(RegRepeatPeriod, 8'd0);
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b0;
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  // first delay then repeat period, fire joining a held direction
  task automatic test_initial_delay();
    sample_t seq[7] = '{8'h08, 8'h08, 8'h08, 8'h08, 8'h18, 8'hFF, 8'h00};
    wait_for_idle();
    write_register(RegInitialDelay, 8'd2);
    write_register(RegRepeatPeriod, 8'd1);
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  // receiver stalls for a long stretch while samples keep coming
  task automatic test_output_backpressure();
    sender_gaps    = 1'b0;
    receiver_gaps  = 1'b0;
    long_stall_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_sample(8'h10);
      send_sample(8'h00);
    end
  endtask

  // mostly held directions and fire taps, with noise mixed in
  task automatic test_random_phase(input logic [7:0] delay, input logic [7:0] period);
    int      sent;
    int      run_len;
    int      style;
    sample_t held;
    sample_t extra;
    wait_for_idle();
    write_register(RegInitialDelay, delay);
    write_register(RegRepeatPeriod, period);
    sent = 0;
    while (sent < PhaseSamples) begin
      sender_gaps   = $urandom_range(0, 3) != 0;
      receiver_gaps = $urandom_range(0, 3) != 0;
      style   = $urandom_range(0, 9);
      run_len = (style < 6) ? $urandom_range(1, 40) : $urandom_range(1, 10);
      held    = sample_t'(1) << $urandom_range(0, 3);
      for (int i = 0; i < run_len && sent < PhaseSamples; i++) begin
        extra = sample_t'($urandom);
        if (style < 6) begin
          // held direction, lower-priority bits may come and go
          send_sample(held | (($urandom_range(0, 2) == 0) ? (extra & ~((held << 1) - 1'b1))
                                                           : sample_t'(0)));
        end else if (style < 8) begin
          // fire taps between idle samples
          send_sample(($urandom_range(0, 2) == 0) ? sample_t'(0) :
                      (extra & 8'hE0) | (sample_t'(1) << (4 + $urandom_range(0, 1))));
        end else begin
          send_sample(extra);
        end
        sent++;
      end
      if (style < 6 && $urandom_range(0, 1) == 1 && sent < PhaseSamples) begin
        send_sample('0);
        sent++;
      end
    end
  endtask

  initial begin : main
    int waited;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_joy_sample     = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    sender_gaps       = 1'b0;
    receiver_gaps     = 1'b0;
    long_stall_req    = 1'b0;
    error_count       = 0;
    samples_sent      = 0;
    events_checked    = 0;
    register_writes   = 0;
    delay_model       = 8'd30;
    period_model      = 8'd6;
    countdown_model   = '0;
    repeating_model   = 1'b0;
    last_sample_model = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_release_cases();
    test_fire_edges();
    test_zero_reload();
    test_initial_delay();
    test_output_backpressure();
    test_random_phase(8'd3, 8'd1);
    test_random_phase(8'd255, 8'd0);
    test_random_phase(8'd0, 8'd255);
    test_random_phase(8'd255, 8'd255);
    test_random_phase(8'd0, 8'd0);
    test_random_phase(8'($urandom_range(0, 20)), 8'($urandom_range(0, 20)));

    // drain the last events, bounded
    in_valid <= 1'b0;
    waited = 0;
    while (pending_events.size() != 0 && waited < EndLimit) begin
      @(negedge clk);
      waited++;
    end
    repeat (SettleCycles) @(negedge clk);
    if (pending_events.size() != 0) begin
      $display("%0t: %0d predicted events never arrived", $time, pending_events.size());
      error_count++;
    end

    $display("Covered %0d samples and %0d events across %0d register writes,",
             samples_sent, events_checked, register_writes);
    $display("including delay and period extremes and a %0d-cycle output stall",
             LongStallCycles);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/jae_pkg.sv
rtl/jae_core.sv
rtl/joystick_autorepeat_events_unit.sv
tb/tb_joystick_autorepeat_events_unit.sv
